/* design/wsd_pkg.sv */
// Shared types and constants for the WebSocket frame deframer.
`default_nettype none

package wsd_pkg;

   typedef enum logic [4:0] {
      PH_HDR1    = 5'b00001,
      PH_HDR2    = 5'b00010,
      PH_EXTLEN  = 5'b00100,
      PH_KEY     = 5'b01000,
      PH_PAYLOAD = 5'b10000
   } phase_type;

   localparam logic [1:0] KIND_HEADER  = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD = 2'd1;
   localparam logic [1:0] KIND_ERROR   = 2'd2;

   localparam logic [6:0] LEN_CODE_EXT16 = 7'd126;
   localparam logic [6:0] LEN_CODE_EXT64 = 7'd127;

   typedef struct packed {
      phase_type   phase;
      logic        fin;
      logic [3:0]  opcode;
      logic        masked;
      logic [1:0]  byte_count;
      logic [15:0] length;
      logic [15:0] remaining;
      logic [31:0] key;
      logic [1:0]  key_index;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:      PH_HDR1,
      fin:        1'b0,
      opcode:     4'd0,
      masked:     1'b0,
      byte_count: 2'd0,
      length:     16'd0,
      remaining:  16'd0,
      key:        32'd0,
      key_index:  2'd0
   };

   typedef struct packed {
      logic [1:0]  kind;
      logic [7:0]  data_byte;
      logic        fin_bit;
      logic [3:0]  op_code;
      logic        was_masked;
      logic [15:0] frame_length;
      logic        last;
   } result_type;

endpackage

`default_nettype wire

/* design/websocket_frame_deframer.sv */
// Top level of the WebSocket frame deframer and payload unmasker.
`default_nettype none

// Takes one received byte per transaction and sustains one byte per clock. A
// byte is held in an input register, goes through the header parser and
// unmasking XOR, and its result (if any) lands in the output register.
// Header and key bytes give no result; the header result comes with the byte
// that completes the header, a length code of 127 gives an error result, and
// each payload byte gives one result. Only the output register stalling on
// rsp_ready holds the input side back.
module websocket_frame_deframer (
   input  wire  logic        clock,
   input  wire  logic        reset,
   input  wire  logic        req_valid,
   output logic              req_ready,
   input  wire  logic [7:0]  req_in_byte,
   output logic              rsp_valid,
   input  wire  logic        rsp_ready,
   output logic [1:0]        rsp_kind,
   output logic [7:0]        rsp_data_byte,
   output logic              rsp_fin_bit,
   output logic [3:0]        rsp_op_code,
   output logic              rsp_was_masked,
   output logic [15:0]       rsp_frame_length,
   output logic              rsp_last
);

   import wsd_pkg::*;

   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       has_result;
   logic       rsp_valid_ff;
   logic       out_free;
   logic       advance;

   wsd_step u_step (
      .cur_state  (state_ff),
      .in_byte    (in_byte_ff),
      .nxt_state  (state_in),
      .result     (result_in),
      .has_result (has_result)
   );

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && out_free;
   assign req_ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= STATE_RESET;
      end else begin
         if (req_valid && req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= advance && has_result;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      if (advance && has_result) begin
         result_ff <= result_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_kind         = result_ff.kind;
   assign rsp_data_byte    = result_ff.data_byte;
   assign rsp_fin_bit      = result_ff.fin_bit;
   assign rsp_op_code      = result_ff.op_code;
   assign rsp_was_masked   = result_ff.was_masked;
   assign rsp_frame_length = result_ff.frame_length;
   assign rsp_last         = result_ff.last;

`ifndef ASSERT_OFF
   a_error_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.kind == KIND_ERROR) |-> result_ff.last)
      else $error("Error result without last flag.");

   a_data_only_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && (result_ff.kind != KIND_PAYLOAD) |-> (result_ff.data_byte == 8'd0))
      else $error("Non-payload result carries data.");

   a_payload_remaining: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_PAYLOAD) |-> (state_ff.remaining != 16'd0))
      else $error("Payload phase with no bytes remaining.");

   a_key_needs_mask: assert property (@(posedge clock) disable iff (reset)
      (state_ff.phase == PH_KEY) |-> state_ff.masked)
      else $error("Key phase entered for an unmasked frame.");
`endif

endmodule

`default_nettype wire

/* design/wsd_step.sv */
// Next-state and result logic for one received byte of the deframer.
`default_nettype none

module wsd_step (
   input  wire  wsd_pkg::state_type  cur_state,
   input  wire  logic [7:0]          in_byte,
   output wsd_pkg::state_type        nxt_state,
   output wsd_pkg::result_type       result,
   output logic                      has_result
);

   import wsd_pkg::*;

   logic [6:0] len_code;
   logic [7:0] key_byte;
   logic       payload_done;

   // Completes the header: payload follows unless the frame is empty.
   function automatic state_type finish_header(state_type s);
      state_type f;
      f            = s;
      f.remaining  = s.length;
      f.key_index  = 2'd0;
      f.byte_count = 2'd0;
      f.phase      = (s.length == 16'd0) ? PH_HDR1 : PH_PAYLOAD;
      return f;
   endfunction

   assign len_code = in_byte[6:0];

   always_comb begin
      case (cur_state.key_index)
         2'd0:    key_byte = cur_state.key[31:24];
         2'd1:    key_byte = cur_state.key[23:16];
         2'd2:    key_byte = cur_state.key[15:8];
         default: key_byte = cur_state.key[7:0];
      endcase
   end

   assign payload_done = (cur_state.remaining == 16'd1);

   always_comb begin
      nxt_state           = cur_state;
      has_result          = 1'b0;
      result.kind         = KIND_HEADER;
      result.data_byte    = 8'd0;
      result.frame_length = cur_state.length;
      result.last         = 1'b0;

      case (cur_state.phase)
         PH_HDR2: begin
            nxt_state.masked     = in_byte[7];
            nxt_state.byte_count = 2'd0;
            if (len_code == LEN_CODE_EXT64) begin
               nxt_state.length    = 16'd0;
               nxt_state.remaining = 16'd0;
               nxt_state.phase     = PH_HDR1;
               has_result          = 1'b1;
               result.kind         = KIND_ERROR;
               result.frame_length = 16'd0;
               result.last         = 1'b1;
            end else if (len_code == LEN_CODE_EXT16) begin
               nxt_state.length = 16'd0;
               nxt_state.phase  = PH_EXTLEN;
            end else begin
               nxt_state.length = {9'd0, len_code};
               if (in_byte[7]) begin
                  nxt_state.phase = PH_KEY;
               end else begin
                  nxt_state           = finish_header(nxt_state);
                  has_result          = 1'b1;
                  result.frame_length = {9'd0, len_code};
                  result.last         = (len_code == 7'd0);
               end
            end
         end
         PH_EXTLEN: begin
            if (cur_state.byte_count == 2'd0) begin
               nxt_state.length     = {in_byte, 8'd0};
               nxt_state.byte_count = 2'd1;
            end else begin
               nxt_state.length     = {cur_state.length[15:8], in_byte};
               nxt_state.byte_count = 2'd0;
               if (cur_state.masked) begin
                  nxt_state.phase = PH_KEY;
               end else begin
                  nxt_state           = finish_header(nxt_state);
                  has_result          = 1'b1;
                  result.frame_length = nxt_state.length;
                  result.last         = (nxt_state.length == 16'd0);
               end
            end
         end
         PH_KEY: begin
            nxt_state.key = {cur_state.key[23:0], in_byte};
            if (cur_state.byte_count != 2'd3) begin
               nxt_state.byte_count = cur_state.byte_count + 2'd1;
            end else begin
               nxt_state   = finish_header(nxt_state);
               has_result  = 1'b1;
               result.last = (cur_state.length == 16'd0);
            end
         end
         PH_PAYLOAD: begin
            nxt_state.key_index = cur_state.key_index + 2'd1;
            nxt_state.remaining = cur_state.remaining - 16'd1;
            if (payload_done) begin
               nxt_state.phase = PH_HDR1;
            end
            has_result       = 1'b1;
            result.kind      = KIND_PAYLOAD;
            result.data_byte = cur_state.masked ? (in_byte ^ key_byte) : in_byte;
            result.last      = payload_done;
         end
         default: begin
            nxt_state.fin    = in_byte[7];
            nxt_state.opcode = in_byte[3:0];
            nxt_state.phase  = PH_HDR2;
         end
      endcase

      result.fin_bit    = nxt_state.fin;
      result.op_code    = nxt_state.opcode;
      result.was_masked = nxt_state.masked;
   end

endmodule

`default_nettype wire

/* tb/sv/deframer_checker.sv */
// Checker for the WebSocket frame deframer: predicts every result and compares it.
`default_nettype none

module deframer_checker (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic [7:0]         req_in_byte,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [1:0]         rsp_kind,
   input  wire logic [7:0]         rsp_data_byte,
   input  wire logic               rsp_fin_bit,
   input  wire logic [3:0]         rsp_op_code,
   input  wire logic               rsp_was_masked,
   input  wire logic [15:0]        rsp_frame_length,
   input  wire logic               rsp_last,
   output int                      failures,
   output int                      pending,
   output wsd_pkg::phase_type      parser_phase
);
   import wsd_pkg::*;

   localparam int PRINT_LIMIT = 100;

   phase_type   phase;
   logic        cur_fin;
   logic [3:0]  cur_opcode;
   logic        cur_masked;
   logic [1:0]  byte_count;
   logic [15:0] hdr_len;
   logic [15:0] remaining;
   logic [31:0] mask_key;
   logic [1:0]  key_pos;
   result_type  deframed_results [$];

   task automatic report_mismatch(input string what);
      if (failures < PRINT_LIMIT) begin
         $display("%0t: mismatch: %s", $time, what);
      end
      failures++;
   endtask

   task automatic compare_field(input string name, input int got, input int want);
      if (got != want) begin
         report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
      end
   endtask

   task automatic push_result(input logic [1:0] kind, input logic [7:0] data,
                              input logic [15:0] flen, input logic last);
      result_type r;
      r.kind         = kind;
      r.data_byte    = data;
      r.fin_bit      = cur_fin;
      r.op_code      = cur_opcode;
      r.was_masked   = cur_masked;
      r.frame_length = flen;
      r.last         = last;
      deframed_results.push_back(r);
   endtask

   task automatic close_header();
      push_result(KIND_HEADER, 8'd0, hdr_len, hdr_len == 16'd0);
      remaining  = hdr_len;
      key_pos    = 2'd0;
      byte_count = 2'd0;
      phase      = (hdr_len == 16'd0) ? PH_HDR1 : PH_PAYLOAD;
   endtask

   task automatic deframe_byte(input logic [7:0] b);
      logic [7:0] key_byte;
      case (phase)
         PH_HDR2: begin
            cur_masked = b[7];
            byte_count = 2'd0;
            if (b[6:0] == LEN_CODE_EXT64) begin
               hdr_len   = 16'd0;
               remaining = 16'd0;
               phase     = PH_HDR1;
               push_result(KIND_ERROR, 8'd0, 16'd0, 1'b1);
            end else if (b[6:0] == LEN_CODE_EXT16) begin
               hdr_len = 16'd0;
               phase   = PH_EXTLEN;
            end else begin
               hdr_len = {9'd0, b[6:0]};
               if (cur_masked) begin
                  phase = PH_KEY;
               end else begin
                  close_header();
               end
            end
         end
         PH_EXTLEN: begin
            if (byte_count == 2'd0) begin
               hdr_len    = {b, 8'h00};
               byte_count = 2'd1;
            end else begin
               hdr_len    = hdr_len | {8'h00, b};
               byte_count = 2'd0;
               if (cur_masked) begin
                  phase = PH_KEY;
               end else begin
                  close_header();
               end
            end
         end
         PH_KEY: begin
            mask_key = {mask_key[23:0], b};
            if (byte_count != 2'd3) begin
               byte_count = byte_count + 2'd1;
            end else begin
               close_header();
            end
         end
         PH_PAYLOAD: begin
            key_byte  = cur_masked ? mask_key[8 * (3 - key_pos) + 7 -: 8] : 8'h00;
            key_pos   = key_pos + 2'd1;
            remaining = remaining - 16'd1;
            if (remaining == 16'd0) begin
               phase = PH_HDR1;
            end
            push_result(KIND_PAYLOAD, b ^ key_byte, hdr_len, remaining == 16'd0);
         end
         default: begin
            cur_fin    = b[7];
            cur_opcode = b[3:0];
            phase      = PH_HDR2;
         end
      endcase
   endtask

   always @(posedge clock) begin
      result_type want;
      if (reset) begin
         phase      = PH_HDR1;
         cur_fin    = 1'b0;
         cur_opcode = 4'd0;
         cur_masked = 1'b0;
         byte_count = 2'd0;
         hdr_len    = 16'd0;
         remaining  = 16'd0;
         mask_key   = 32'd0;
         key_pos    = 2'd0;
         deframed_results.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (deframed_results.size() == 0) begin
               report_mismatch($sformatf("result of kind %0d with nothing outstanding",
                                         rsp_kind));
            end else begin
               want = deframed_results.pop_front();
               compare_field("kind", int'(rsp_kind), int'(want.kind));
               compare_field("data_byte", int'(rsp_data_byte), int'(want.data_byte));
               compare_field("fin_bit", int'(rsp_fin_bit), int'(want.fin_bit));
               compare_field("op_code", int'(rsp_op_code), int'(want.op_code));
               compare_field("was_masked", int'(rsp_was_masked), int'(want.was_masked));
               compare_field("frame_length", int'(rsp_frame_length),
                             int'(want.frame_length));
               compare_field("last", int'(rsp_last), int'(want.last));
            end
         end
         if (req_valid && req_ready) begin
            deframe_byte(req_in_byte);
         end
      end
      pending      = deframed_results.size();
      parser_phase = phase;
   end

endmodule

`default_nettype wire

/* tb/sv/testbench.sv */
// Top of the deframer testbench: clock, reset, byte stimulus and the final verdict.
`default_nettype none

module testbench;
   import wsd_pkg::*;

   localparam int QUIET_LIMIT  = 1000;
   localparam int RANDOM_BYTES = 600;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_ready   = 1'b0;
   logic        req_ready;
   logic        rsp_valid;
   logic [1:0]  rsp_kind;
   logic [7:0]  rsp_data_byte;
   logic        rsp_fin_bit;
   logic [3:0]  rsp_op_code;
   logic        rsp_was_masked;
   logic [15:0] rsp_frame_length;
   logic        rsp_last;

   int          send_idle_pct = 36;
   int          take_idle_pct = 36;
   int          bytes_sent    = 0;
   int          quiet_cycles  = 0;
   int          failures;
   int          pending;
   phase_type   parser_phase;

   always #10 clock = ~clock;

   websocket_frame_deframer dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_fin_bit      (rsp_fin_bit),
      .rsp_op_code      (rsp_op_code),
      .rsp_was_masked   (rsp_was_masked),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last)
   );

   deframer_checker deframe_check (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_in_byte      (req_in_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_data_byte    (rsp_data_byte),
      .rsp_fin_bit      (rsp_fin_bit),
      .rsp_op_code      (rsp_op_code),
      .rsp_was_masked   (rsp_was_masked),
      .rsp_frame_length (rsp_frame_length),
      .rsp_last         (rsp_last),
      .failures         (failures),
      .pending          (pending),
      .parser_phase     (parser_phase)
   );

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= take_idle_pct);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid   = 1'b1;
      req_in_byte = value;
      forever begin
         @(posedge clock);
         if (req_ready) break;
      end
      bytes_sent++;
      @(negedge clock);
   endtask

   task automatic send_frame(input logic [7:0] lead, input logic masked, input int length,
                             input logic wide, input logic [31:0] key);
      send_byte(lead);
      if (wide) begin
         send_byte({masked, LEN_CODE_EXT16});
         send_byte(length[15:8]);
         send_byte(length[7:0]);
      end else begin
         send_byte({masked, length[6:0]});
      end
      if (masked) begin
         send_byte(key[31:24]);
         send_byte(key[23:16]);
         send_byte(key[15:8]);
         send_byte(key[7:0]);
      end
      repeat (length) send_byte(8'($urandom_range(255)));
   endtask

   task automatic send_error(input logic [7:0] lead, input logic masked);
      send_byte(lead);
      send_byte({masked, LEN_CODE_EXT64});
   endtask

   // Extended length bytes are kept to 0 or 1 so that stray headers stay short.
   function automatic logic [7:0] noise_value();
      return (parser_phase == PH_EXTLEN) ? 8'($urandom_range(1)) : 8'($urandom_range(255));
   endfunction

   task automatic send_noise(input int count);
      repeat (count) send_byte(noise_value());
      while (parser_phase != PH_HDR1) send_byte(noise_value());
   endtask

   task automatic wait_drained();
      req_valid = 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   initial begin
      int random_start;
      int frame_index;
      int pick;
      int length;
      logic wide;
      repeat (6) @(negedge clock);
      reset = 1'b0;

      send_frame(8'h81, 1'b0, 0, 1'b0, 32'h0);
      send_error(8'h0F, 1'b1);
      send_frame(8'h82, 1'b1, 5, 1'b0, 32'hFF00AA55);
      send_frame(8'h78, 1'b0, 0, 1'b1, 32'h0);
      send_frame(8'h70, 1'b1, 1, 1'b1, 32'hDEADBEEF);
      wait_drained();

      random_start = bytes_sent;
      frame_index  = 0;
      while (bytes_sent - random_start < RANDOM_BYTES) begin
         if (frame_index >= 30 && frame_index < 60) begin
            send_idle_pct = 0;
            take_idle_pct = 0;
         end else begin
            send_idle_pct = 36;
            take_idle_pct = 36;
         end
         pick = $urandom_range(99);
         if (pick < 70) begin
            pick = $urandom_range(99);
            wide = 1'b0;
            if (pick < 70) begin
               length = $urandom_range(12);
            end else if (pick < 85) begin
               length = $urandom_range(125, 13);
            end else begin
               length = $urandom_range(300);
               wide   = 1'b1;
            end
            send_frame(8'($urandom_range(255)), 1'($urandom_range(1)), length, wide,
                       $urandom);
         end else if (pick < 82) begin
            send_error(8'($urandom_range(255)), 1'($urandom_range(1)));
            if ($urandom_range(1)) send_noise(8);
         end else begin
            send_noise($urandom_range(6, 1));
         end
         if ($urandom_range(99) < 4) wait_drained();
         frame_index++;
      end

      wait_drained();
      repeat (8) @(negedge clock);
      if (failures == 0 && pending == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

`default_nettype wire

/* sim.f */
design/wsd_pkg.sv
design/wsd_step.sv
design/websocket_frame_deframer.sv
tb/sv/deframer_checker.sv
tb/sv/testbench.sv
